>>> rtl/med_pkg.sv
// ----------------------------------------------------------------------------
// med_pkg: shared constants and types for the median echo distance filter
// Group size, field widths and the reciprocal used for the divide by 58.
// ----------------------------------------------------------------------------
package med_pkg;

  // Samples per group; any value from three through nine
  localparam int unsigned SamplesPerResult = 5;
  localparam int unsigned CntW = $clog2(SamplesPerResult);
  localparam int unsigned IdxW = (SamplesPerResult - 1 > 1) ? $clog2(SamplesPerResult - 1) : 1;
  localparam int unsigned MedianIdx = SamplesPerResult / 2;

  localparam int unsigned EchoW = 16;
  localparam int unsigned DistW = 10;

  localparam logic [DistW-1:0] MaxDistReset = DistW'(400);
  localparam logic [DistW-1:0] MinDistance = DistW'(2);

  // floor(m / 58) == (m * 36158) >> 21 for every 16-bit m
  localparam int unsigned RecipShift = 21;
  localparam int unsigned ProdW = 32;
  localparam logic [EchoW-1:0] Recip58 = EchoW'(36158);
  localparam int unsigned QuotW = ProdW - RecipShift;

  typedef logic [EchoW-1:0] echo_t;
  typedef echo_t [SamplesPerResult-1:0] group_t;

endpackage

>>> rtl/median_echo_distance.sv
// ----------------------------------------------------------------------------
// median_echo_distance: median-of-five ultrasonic distance filter
// Groups echo widths, takes their median and reports centimeters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / echo_time_i): one beat per echo
//   width in microseconds, zero on timeout. A beat is taken in any cycle in
//   which the group register is free or drains, so one beat per cycle.
//   Every fifth beat closes a group and yields one result beat on the output
//   channel (out_valid_o / out_stall_i / distance_cm_o / no_echo_o); the
//   other beats yield nothing.
//   Path: the closing beat completes the group in the group register; its
//   result then passes through the median network, divide and clamp into
//   the output register.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_max_distance_i): always
//   ready; write the limit only while the block is idle.
//   Reset: group count cleared, no result pending, limit back to 400 cm.
//   Stall: the output register holds its beat; one closed group waits in the
//   group register, and only once that is full does in_stall_o rise.
// ----------------------------------------------------------------------------
module median_echo_distance (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [med_pkg::DistW-1:0] cfg_max_distance_i,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [med_pkg::EchoW-1:0] echo_time_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [med_pkg::DistW-1:0] distance_cm_o,
  output logic                      no_echo_o
);

  logic [med_pkg::DistW-1:0] max_dist_q;
  logic                      out_valid_q, out_valid_d;
  logic [med_pkg::DistW-1:0] dist_q;
  logic                      no_echo_q;

  logic                      out_load;
  logic                      grp_free;
  logic                      accept;
  logic                      grp_valid;
  med_pkg::group_t           group;
  med_pkg::echo_t            median;
  logic [med_pkg::DistW-1:0] dist_c;
  logic                      no_echo_c;

  // Config register: single write port, never busy
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= med_pkg::MaxDistReset;
    end else if (cfg_valid_i) begin
      max_dist_q <= cfg_max_distance_i;
    end
  end

  // Load the output register when it is empty or its beat leaves this cycle
  assign out_load   = !out_valid_q || !out_stall_i;
  // The group register frees up when empty or when it drains into the output
  assign grp_free   = !grp_valid || out_load;
  assign in_stall_o = !grp_free;
  assign accept     = in_valid_i && grp_free;

  med_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .echo_time_i (echo_time_i),
    .drain_i     (out_load),
    .grp_valid_o (grp_valid),
    .group_o     (group)
  );

  med_median u_median (
    .group_i  (group),
    .median_o (median)
  );

  med_scale u_scale (
    .median_i       (median),
    .max_distance_i (max_dist_q),
    .distance_cm_o  (dist_c),
    .no_echo_o      (no_echo_c)
  );

  // Output register: advance on load, hold while stalled
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = grp_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && grp_valid) begin
      dist_q    <= dist_c;
      no_echo_q <= no_echo_c;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_cm_o = dist_q;
  assign no_echo_o     = no_echo_q;

endmodule

>>> rtl/med_collect.sv
// ----------------------------------------------------------------------------
// med_collect: sample store and group register
// Holds the first samples of a group and captures the full group on the last.
// ----------------------------------------------------------------------------
module med_collect (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  med_pkg::echo_t  echo_time_i,
  input  logic            drain_i,
  output logic            grp_valid_o,
  output med_pkg::group_t group_o
);

  logic [med_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     grp_valid_q, grp_valid_d;
  med_pkg::echo_t           store_q [med_pkg::SamplesPerResult-1];
  med_pkg::group_t          group_q;
  logic                     last;

  assign last = (cnt_q == med_pkg::CntW'(med_pkg::SamplesPerResult - 1));

  always_comb begin
    cnt_d       = cnt_q;
    grp_valid_d = grp_valid_q;
    if (drain_i) begin
      grp_valid_d = 1'b0;
    end
    if (accept_i) begin
      if (last) begin
        cnt_d       = '0;
        grp_valid_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      grp_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      grp_valid_q <= grp_valid_d;
    end
  end

  // payload: store entries and group register carry no reset
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (last) begin
        for (int i = 0; i < med_pkg::SamplesPerResult - 1; i++) begin
          group_q[i] <= store_q[i];
        end
        group_q[med_pkg::SamplesPerResult-1] <= echo_time_i;
      end else begin
        store_q[cnt_q[med_pkg::IdxW-1:0]] <= echo_time_i;
      end
    end
  end

  assign grp_valid_o = grp_valid_q;
  assign group_o     = group_q;

endmodule

>>> rtl/med_median.sv
// ----------------------------------------------------------------------------
// med_median: median of one group
// Odd-even transposition sorting network; picks the upper middle element.
// ----------------------------------------------------------------------------
module med_median (
  input  med_pkg::group_t group_i,
  output med_pkg::echo_t  median_o
);

  med_pkg::group_t sorted;

  always_comb begin
    med_pkg::echo_t tmp;
    tmp    = '0;
    sorted = group_i;
    for (int p = 0; p < med_pkg::SamplesPerResult; p++) begin
      for (int i = p % 2; i + 1 < med_pkg::SamplesPerResult; i += 2) begin
        if (sorted[i] > sorted[i+1]) begin
          tmp         = sorted[i];
          sorted[i]   = sorted[i+1];
          sorted[i+1] = tmp;
        end
      end
    end
  end

  assign median_o = sorted[med_pkg::MedianIdx];

endmodule

>>> rtl/med_scale.sv
// ----------------------------------------------------------------------------
// med_scale: microseconds to centimeters with clamping
// Divide by 58 through a reciprocal product, clamp to two through the limit.
// ----------------------------------------------------------------------------
module med_scale (
  input  med_pkg::echo_t                median_i,
  input  logic [med_pkg::DistW-1:0]     max_distance_i,
  output logic [med_pkg::DistW-1:0]     distance_cm_o,
  output logic                          no_echo_o
);

  logic [med_pkg::DistW-1:0] limit;
  logic [med_pkg::ProdW-1:0] prod;
  logic [med_pkg::QuotW-1:0] quot;

  assign limit = (max_distance_i < med_pkg::MinDistance) ? med_pkg::MinDistance
                                                         : max_distance_i;
  assign prod  = med_pkg::ProdW'(median_i) * med_pkg::ProdW'(med_pkg::Recip58);
  assign quot  = prod[med_pkg::ProdW-1:med_pkg::RecipShift];

  always_comb begin
    no_echo_o     = 1'b0;
    distance_cm_o = limit;
    if (median_i == '0) begin
      no_echo_o = 1'b1;
    end else if (quot < med_pkg::QuotW'(med_pkg::MinDistance)) begin
      distance_cm_o = med_pkg::MinDistance;
    end else if (quot < med_pkg::QuotW'(limit)) begin
      distance_cm_o = quot[med_pkg::DistW-1:0];
    end
  end

endmodule
